FILE: rtl/core/sfh_pkg.sv
package sfh_pkg;

  localparam int unsigned HashW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // Byte counts after clamping
  localparam logic [CountW-1:0] CntEmpty = 3'd0;
  localparam logic [CountW-1:0] CntOne   = 3'd1;
  localparam logic [CountW-1:0] CntTwo   = 3'd2;
  localparam logic [CountW-1:0] CntThree = 3'd3;
  localparam logic [CountW-1:0] CntFull  = 3'd4;

  // Request from the front end to the finishing pipeline
  typedef struct packed {
    logic             valid;
    logic [HashW-1:0] pre_hash;
  } sfh_req_t;

  // One main-loop round or one tail step, selected by the clamped count
  function automatic logic [HashW-1:0] sfh_round(input logic [HashW-1:0] h_in,
                                                 input logic [HashW-1:0] word,
                                                 input logic [CountW-1:0] cnt);
    logic [HashW-1:0] h;
    logic [HashW-1:0] t;
    logic [15:0]      lo;
    logic [15:0]      hi;
    lo = word[15:0];
    hi = word[31:16];
    h  = h_in;
    t  = '0;
    case (cnt)
      CntFull: begin
        h = h + {16'd0, lo};
        t = ({16'd0, hi} << 11) ^ h;
        h = (h << 16) ^ t;
        h = h + (h >> 11);
      end
      CntThree: begin
        h = h + {16'd0, lo};
        h = h ^ (h << 16);
        h = h ^ ({24'd0, hi[7:0]} << 18);
        h = h + (h >> 11);
      end
      CntTwo: begin
        h = h + {16'd0, lo};
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      default: begin
        h = h + {24'd0, word[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
    endcase
    return h;
  endfunction

  // First three avalanche steps
  function automatic logic [HashW-1:0] sfh_aval_a(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    return h;
  endfunction

  // Last three avalanche steps
  function automatic logic [HashW-1:0] sfh_aval_b(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in;
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

endpackage

FILE: rtl/core/sfh_front.sv
module sfh_front import sfh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [HashW-1:0]  chunk_word_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic              first_chunk_i,
  input  logic              last_chunk_i,
  input  logic [HashW-1:0]  seed_value_i,
  output sfh_req_t          req_o
);

  logic [HashW-1:0]  running_q, running_d;
  logic              in_msg_q, in_msg_d;
  logic [CountW-1:0] cnt;
  logic [HashW-1:0]  base;
  logic [HashW-1:0]  rounded;

  // Clamp counts above four to a full chunk
  assign cnt     = byte_count_i[2] ? CntFull : byte_count_i;
  assign base    = first_chunk_i ? seed_value_i : running_q;
  assign rounded = sfh_round(base, chunk_word_i, cnt);

  // Classify the chunk and update the running state
  always_comb begin
    running_d      = running_q;
    in_msg_d       = in_msg_q;
    req_o.valid    = 1'b0;
    req_o.pre_hash = running_q;
    if (accept_i) begin
      if (cnt == CntEmpty) begin
        if (last_chunk_i && first_chunk_i) begin
          // empty message hashes to zero, and the avalanche keeps zero
          in_msg_d       = 1'b0;
          req_o.valid    = 1'b1;
          req_o.pre_hash = '0;
        end else if (last_chunk_i && in_msg_q) begin
          in_msg_d    = 1'b0;
          req_o.valid = 1'b1;
        end
      end else if (first_chunk_i || in_msg_q) begin
        running_d      = rounded;
        req_o.pre_hash = rounded;
        if (cnt == CntFull && !last_chunk_i) begin
          in_msg_d = 1'b1;
        end else begin
          in_msg_d    = 1'b0;
          req_o.valid = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= '0;
      in_msg_q  <= 1'b0;
    end else begin
      running_q <= running_d;
      in_msg_q  <= in_msg_d;
    end
  end

endmodule

FILE: rtl/core/sfh_fifo.sv
module sfh_fifo import sfh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [HashW-1:0] data_i,
  input  logic             pop_i,
  output logic [HashW-1:0] data_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [FifoCntW-1:0] count_o
);

  logic [HashW-1:0]    mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                do_push;
  logic                do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/core/sfh_back.sv
module sfh_back import sfh_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fq_empty_i,
  input  logic [HashW-1:0] fq_data_i,
  output logic             fq_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [HashW-1:0] hash_out_o,
  output logic             stage_stall_o
);

  logic             s1_v_q;
  logic [HashW-1:0] s1_q;
  logic             out_v_q;
  logic [HashW-1:0] out_q;
  logic             out_ready;
  logic             s1_move;

  assign out_ready     = !out_v_q || pop_i;
  assign s1_move       = s1_v_q && out_ready;
  assign fq_pop_o      = !fq_empty_i && (!s1_v_q || s1_move);
  assign empty_o       = !out_v_q;
  assign hash_out_o    = out_q;
  assign stage_stall_o = s1_v_q && !out_ready;

  // Hold valid bits; advance when the next stage has room
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (fq_pop_o) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (pop_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Split the avalanche over two registered stages
  always_ff @(posedge clk_i) begin
    if (fq_pop_o) begin
      s1_q <= sfh_aval_a(fq_data_i);
    end
    if (s1_move) begin
      out_q <= sfh_aval_b(s1_q);
    end
  end

endmodule

FILE: rtl/core/superfasthash_stream_top.sv
// Streaming 32-bit SuperFastHash.
// Input channel: present one chunk (chunk_word_i, byte_count_i, first_chunk_i,
// last_chunk_i, seed_value_i) with push; the transaction completes on a
// rising edge where push is high and full is low. A chunk may be pushed
// every cycle; the round on the running hash finishes in the accepting cycle.
// Result channel: while empty is low, hash_out_o carries the oldest finished
// hash; it is taken on an edge where pop is high.
// Path: a finished hash is written into the request queue on the edge that
// accepts the chunk ending its message, then passes through two avalanche
// stages, the second being the output register.
// Throughput: one chunk per cycle while full is low (the front-end round
// is combinational); the avalanche moves one hash per cycle while pop keeps up.
// When pop stays low the pipeline fills, then the 4-entry request queue;
// full rises once the queue holds four pending hashes. Chunks that make no
// hash never wait on the queue's contents, only on full.
// Reset clears the running hash, closes any open message, and empties the
// queue and pipeline; the block accepts chunks right after reset.
module superfasthash_stream_top import sfh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [HashW-1:0]  chunk_word_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic              first_chunk_i,
  input  logic              last_chunk_i,
  input  logic [HashW-1:0]  seed_value_i,
  output logic              empty,
  input  logic              pop,
  output logic [HashW-1:0]  hash_out_o
);

  sfh_req_t            req;
  logic                accept;
  logic                fq_full;
  logic                fq_empty;
  logic                fq_pop;
  logic [HashW-1:0]    fq_data;
  logic [FifoCntW-1:0] fq_count;
  logic                stage_stall;

  assign accept = push && !fq_full;
  assign full   = fq_full;

  sfh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .chunk_word_i  (chunk_word_i),
    .byte_count_i  (byte_count_i),
    .first_chunk_i (first_chunk_i),
    .last_chunk_i  (last_chunk_i),
    .seed_value_i  (seed_value_i),
    .req_o         (req)
  );

  sfh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (req.valid),
    .data_i  (req.pre_hash),
    .pop_i   (fq_pop),
    .data_o  (fq_data),
    .full_o  (fq_full),
    .empty_o (fq_empty),
    .count_o (fq_count)
  );

  sfh_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fq_empty_i    (fq_empty),
    .fq_data_i     (fq_data),
    .fq_pop_o      (fq_pop),
    .pop_i         (pop),
    .empty_o       (empty),
    .hash_out_o    (hash_out_o),
    .stage_stall_o (stage_stall)
  );

  // A request is only made for an accepted chunk, and never into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) req.valid |-> accept)
    else $error("hash request without accepted chunk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fq_count <= FifoCntW'(FifoDepth))
    else $error("request queue overflow");

  // Queue is drained only when it holds something
  assert property (@(posedge clk_i) disable iff (!rst_ni) fq_pop |-> !fq_empty)
    else $error("pop from empty request queue");

  // Hold the queue while the first avalanche stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_stall |-> !fq_pop)
    else $error("first stage overwritten while stalled");

endmodule

FILE: dv/superfasthash_stream_checker.sv
`timescale 1ns / 1ps

module superfasthash_stream_checker import sfh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  input  logic              full,
  input  logic [HashW-1:0]  chunk_word_i,
  input  logic [CountW-1:0] byte_count_i,
  input  logic              first_chunk_i,
  input  logic              last_chunk_i,
  input  logic [HashW-1:0]  seed_value_i,
  input  logic              empty,
  input  logic              pop,
  input  logic [HashW-1:0]  hash_out_o,
  output int unsigned       fail_count,
  output int unsigned       hashes_pending
);

  // Predicted message state
  logic [HashW-1:0] msg_hash;
  logic             msg_open;
  logic [HashW-1:0] expected_hashes[$];

  // Fold one chunk into the running hash: full round or tail step
  function automatic logic [HashW-1:0] mix_chunk(input logic [HashW-1:0]  h_in,
                                                 input logic [HashW-1:0]  word,
                                                 input logic [CountW-1:0] cnt);
    logic [HashW-1:0] h;
    logic [HashW-1:0] lo_half;
    logic [HashW-1:0] hi_half;
    lo_half = {16'd0, word[15:0]};
    hi_half = {16'd0, word[31:16]};
    h = h_in;
    case (cnt)
      CntFull: begin
        h = h + lo_half;
        h = (h << 16) ^ ((hi_half << 11) ^ h);
        h = h + (h >> 11);
      end
      CntThree: begin
        h = h + lo_half;
        h = h ^ (h << 16);
        h = h ^ ({24'd0, word[23:16]} << 18);
        h = h + (h >> 11);
      end
      CntTwo: begin
        h = h + lo_half;
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      default: begin
        h = h + {24'd0, word[7:0]};
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
    endcase
    return h;
  endfunction

  // Six-step final mix
  function automatic logic [HashW-1:0] finalize_hash(input logic [HashW-1:0] h_in);
    logic [HashW-1:0] h;
    h = h_in;
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [CountW-1:0] cnt;
    logic [HashW-1:0]  h;
    if (!rst_ni) begin
      msg_hash = '0;
      msg_open = 1'b0;
      expected_hashes.delete();
      fail_count = 0;
      hashes_pending = 0;
    end else begin
      // Compare a popped hash against the oldest prediction
      if (pop && !empty) begin
        if (expected_hashes.size() == 0) begin
          $error("hash_out_o: unexpected result %h", hash_out_o);
          fail_count++;
        end else begin
          h = expected_hashes.pop_front();
          if (hash_out_o !== h) begin
            $error("hash_out_o mismatch: expected %h, actual %h", h, hash_out_o);
            fail_count++;
          end
        end
      end
      // Predict the outcome of an accepted chunk
      if (push && !full) begin
        cnt = (byte_count_i > CntFull) ? CntFull : byte_count_i;
        if (cnt == CntEmpty) begin
          if (last_chunk_i) begin
            if (first_chunk_i) begin
              msg_open = 1'b0;
              expected_hashes.push_back('0);
            end else if (msg_open) begin
              msg_open = 1'b0;
              expected_hashes.push_back(finalize_hash(msg_hash));
            end
          end
        end else if (first_chunk_i || msg_open) begin
          h = mix_chunk(first_chunk_i ? seed_value_i : msg_hash, chunk_word_i, cnt);
          msg_hash = h;
          msg_open = 1'b1;
          // Short chunks always close the message
          if (cnt != CntFull || last_chunk_i) begin
            msg_open = 1'b0;
            expected_hashes.push_back(finalize_hash(h));
          end
        end
      end
      hashes_pending = expected_hashes.size();
    end
  end

endmodule

FILE: dv/superfasthash_stream_top_tb.sv
`timescale 1ns / 1ps

module superfasthash_stream_top_tb import sfh_pkg::*; ();

  localparam int unsigned ChunksPerPhase = 440;
  localparam int unsigned NumPhases      = 4;

  logic              clk_i;
  logic              rst_ni;
  logic              push;
  logic              full;
  logic [HashW-1:0]  chunk_word_i;
  logic [CountW-1:0] byte_count_i;
  logic              first_chunk_i;
  logic              last_chunk_i;
  logic [HashW-1:0]  seed_value_i;
  logic              empty;
  logic              pop;
  logic [HashW-1:0]  hash_out_o;

  int unsigned fail_count;
  int unsigned hashes_pending;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned msg_chunks;

  superfasthash_stream_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .chunk_word_i (chunk_word_i),
    .byte_count_i (byte_count_i),
    .first_chunk_i(first_chunk_i),
    .last_chunk_i (last_chunk_i),
    .seed_value_i (seed_value_i),
    .empty        (empty),
    .pop          (pop),
    .hash_out_o   (hash_out_o)
  );

  superfasthash_stream_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .chunk_word_i  (chunk_word_i),
    .byte_count_i  (byte_count_i),
    .first_chunk_i (first_chunk_i),
    .last_chunk_i  (last_chunk_i),
    .seed_value_i  (seed_value_i),
    .empty         (empty),
    .pop           (pop),
    .hash_out_o    (hash_out_o),
    .fail_count    (fail_count),
    .hashes_pending(hashes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("superfasthash_stream_top_tb failed");
    $finish;
  end

  // Drain side: stall pop at the current rate
  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk_i);
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Present one chunk, idling first at the current rate; return after an edge once full reads low
  task automatic send_chunk(input logic [HashW-1:0]  word,
                            input logic [CountW-1:0] cnt,
                            input logic              first,
                            input logic              last,
                            input logic [HashW-1:0]  seed);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    chunk_word_i  <= word;
    byte_count_i  <= cnt;
    first_chunk_i <= first;
    last_chunk_i  <= last;
    seed_value_i  <= seed;
    do @(posedge clk_i); while (full);
  endtask

  // One well-formed message with random content and a random ending
  task automatic send_message();
    int unsigned      n_full;
    int unsigned      ending;
    logic [HashW-1:0] seed;
    n_full = ($urandom_range(19) == 0) ? $urandom_range(24) : $urandom_range(5);
    ending = $urandom_range(4);
    seed   = $urandom;
    for (int unsigned i = 0; i < n_full; i++) begin
      // Sprinkle 0-byte chunks that must leave the message alone
      if (i != 0 && $urandom_range(9) == 0) begin
        send_chunk($urandom, CntEmpty, 1'($urandom_range(1)), 1'b0, $urandom);
      end
      send_chunk($urandom, CntFull, i == 0, 1'b0, (i == 0) ? seed : $urandom);
    end
    case (ending)
      0: send_chunk($urandom, CntFull, n_full == 0, 1'b1, seed);
      1: send_chunk($urandom, CntEmpty, n_full == 0, 1'b1, seed);
      2: send_chunk($urandom, 3'($urandom_range(7, 5)), n_full == 0, 1'b1, seed);
      3: begin
        // Abandon the message without closing it
      end
      default: begin
        send_chunk($urandom, 3'($urandom_range(3, 1)), n_full == 0,
                   1'($urandom_range(1)), seed);
      end
    endcase
    msg_chunks += n_full + 1;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    push          <= 1'b0;
    chunk_word_i  <= '0;
    byte_count_i  <= '0;
    first_chunk_i <= 1'b0;
    last_chunk_i  <= 1'b0;
    seed_value_i  <= '0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    msg_chunks    = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty message, ignored chunks, extremes of word and seed
    send_chunk(32'hFFFF_FFFF, CntEmpty, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_chunk(32'h1234_5678, CntFull, 1'b0, 1'b1, 32'h0);
    send_chunk(32'hFFFF_FFFF, CntEmpty, 1'b1, 1'b0, 32'hFFFF_FFFF);
    send_chunk(32'h0, CntFull, 1'b1, 1'b1, 32'h0);
    send_chunk(32'hFFFF_FFFF, CntFull, 1'b1, 1'b1, 32'hFFFF_FFFF);
    // Tail steps as single-chunk messages
    send_chunk(32'hFFFF_FFFF, CntOne, 1'b1, 1'b1, 32'hFFFF_FFFF);
    send_chunk(32'hFFFF_FFFF, CntTwo, 1'b1, 1'b0, 32'h0);
    send_chunk(32'hFFFF_FFFF, CntThree, 1'b1, 1'b1, 32'hA5A5_5A5A);
    // Counts above four behave as full chunks
    send_chunk(32'hDEAD_BEEF, 3'd5, 1'b1, 1'b1, 32'h1);
    send_chunk(32'hCAFE_F00D, 3'd7, 1'b1, 1'b0, 32'h2);
    send_chunk(32'h0BAD_F00D, 3'd6, 1'b0, 1'b1, 32'h3);
    // Multi-chunk message closed by an empty last chunk
    send_chunk(32'h0403_0201, CntFull, 1'b1, 1'b0, 32'h8000_0000);
    send_chunk(32'h0807_0605, CntFull, 1'b0, 1'b0, 32'h0);
    send_chunk(32'h0, CntEmpty, 1'b1, 1'b0, 32'h0);
    send_chunk(32'h0C0B_0A09, CntFull, 1'b0, 1'b0, 32'h0);
    send_chunk(32'h0, CntEmpty, 1'b0, 1'b1, 32'h0);
    // Empty last chunk with no open message is ignored
    send_chunk(32'h0, CntEmpty, 1'b0, 1'b1, 32'h0);
    // A new first chunk abandons the open message
    send_chunk(32'h1111_1111, CntFull, 1'b1, 1'b0, 32'h7);
    send_chunk(32'h2222_2222, CntFull, 1'b1, 1'b0, 32'h9);
    // Short chunk ends the message even without last
    send_chunk(32'hFF33_3333, CntThree, 1'b0, 1'b0, 32'h0);
    send_chunk(32'h4444_4444, CntTwo, 1'b0, 1'b1, 32'h0);
    send_chunk(32'h0000_00FF, CntOne, 1'b1, 1'b0, 32'h0);

    // Random: sweep through the idle and stall mixes
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 61; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 61; end
        default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
      endcase
      msg_chunks = 0;
      while (msg_chunks < ChunksPerPhase) begin
        if ($urandom_range(99) < 12) begin
          send_chunk($urandom, 3'($urandom_range(7)), 1'($urandom_range(1)),
                     1'($urandom_range(1)), $urandom);
          msg_chunks++;
        end else begin
          send_message();
        end
      end
    end
    push         <= 1'b0;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;

    // Drain, then watch for stray results
    wait (hashes_pending == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("superfasthash_stream_top_tb passed");
    end else begin
      $display("superfasthash_stream_top_tb failed");
    end
    $finish;
  end

endmodule
